// File: hw/rtl/ptaf_pkg.sv
`default_nettype none

package ptaf_pkg;

   // Widths of the pixel channels and of the packed color registers.
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned COLOR_W = 3 * CHAN_W;
   localparam int unsigned CSR_IDX_W = 2;

   // Bit offsets of each channel inside a packed color register.
   localparam int unsigned RED_LSB   = 0;
   localparam int unsigned GREEN_LSB = 8;
   localparam int unsigned BLUE_LSB  = 16;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FG_COLOR      = 2'd0,
      CSR_BK_COLOR      = 2'd1,
      CSR_HAS_ALPHA     = 2'd2,
      CSR_FLATTEN_ALPHA = 2'd3
   } csr_idx_type;

   localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;
   localparam logic [CHAN_W-1:0] ROUND_HALF = 8'd127;

   localparam logic [COLOR_W-1:0] FG_RESET = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] BK_RESET = 24'h000000;

   // Pipeline control shared by the lanes: load enables and valid bits.
   typedef struct packed {
      logic en_s1;
      logic en_s2;
      logic en_s3;
      logic vld_s1;
      logic vld_s2;
      logic vld_s3;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

// File: hw/rtl/ptaf_pipe_ctrl.sv
`default_nettype none

module ptaf_pipe_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output ptaf_pkg::pipe_ctrl_type     ctrl
);
   import ptaf_pkg::*;

   logic vld_s1_ff, vld_s2_ff, vld_s3_ff;
   logic en_s1, en_s2, en_s3;

   // A stage loads when it is empty or when its content moves on.
   assign en_s3 = !vld_s3_ff || !rsp_stall;
   assign en_s2 = !vld_s2_ff || en_s3;
   assign en_s1 = !vld_s1_ff || en_s2;

   assign req_stall = !en_s1;
   assign rsp_valid = vld_s3_ff;

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s1_ff <= 1'b0;
         vld_s2_ff <= 1'b0;
         vld_s3_ff <= 1'b0;
      end else begin
         if (en_s1) vld_s1_ff <= req_valid;
         if (en_s2) vld_s2_ff <= vld_s1_ff;
         if (en_s3) vld_s3_ff <= vld_s2_ff;
      end
   end

   assign ctrl.en_s1  = en_s1;
   assign ctrl.en_s2  = en_s2;
   assign ctrl.en_s3  = en_s3;
   assign ctrl.vld_s1 = vld_s1_ff;
   assign ctrl.vld_s2 = vld_s2_ff;
   assign ctrl.vld_s3 = vld_s3_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ptaf_lane.sv
`default_nettype none

module ptaf_lane (
   input  wire logic                          clock,
   input  wire ptaf_pkg::pipe_ctrl_type       ctrl,
   input  wire logic [ptaf_pkg::CHAN_W-1:0]   chan_in,
   input  wire logic [ptaf_pkg::CHAN_W-1:0]   fg_chan,
   input  wire logic [ptaf_pkg::CHAN_W-1:0]   bk_chan,
   input  wire logic [ptaf_pkg::CHAN_W-1:0]   alpha_s1,
   input  wire logic [ptaf_pkg::CHAN_W-1:0]   alpha_s2,
   input  wire logic                          flat_s2,
   output logic      [ptaf_pkg::CHAN_W-1:0]   chan_out
);
   import ptaf_pkg::*;

   // Stage 1: signed color span times the inverted channel.
   logic signed [CHAN_W:0]     span;
   logic signed [2*CHAN_W+1:0] prod_in;
   logic signed [2*CHAN_W+1:0] prod_ff;
   logic [CHAN_W-1:0]          fg_s1_ff, bk_s1_ff;

   assign span    = $signed({1'b0, fg_chan}) - $signed({1'b0, bk_chan});
   assign prod_in = span * $signed({1'b0, ~chan_in});

   always_ff @(posedge clock) begin
      if (ctrl.en_s1) begin
         prod_ff  <= prod_in;
         fg_s1_ff <= fg_chan;
         bk_s1_ff <= bk_chan;
      end
   end

   // Stage 2: floor shift, tint with clamp, and the two blend products.
   logic signed [CHAN_W+1:0]  step;
   logic signed [CHAN_W+2:0]  tint_wide;
   logic [CHAN_W-1:0]         tint;
   logic [2*CHAN_W-1:0]       fore_in, back_in;
   logic [2*CHAN_W-1:0]       fore_ff, back_ff;
   logic [CHAN_W-1:0]         tint_s2_ff, bk_s2_ff;

   assign step      = prod_ff[2*CHAN_W+1:CHAN_W];
   assign tint_wide = $signed({3'b000, fg_s1_ff}) - (CHAN_W+3)'(step);

   always_comb begin
      if (tint_wide < 0) begin
         tint = CHAN_ZERO;
      end else if (tint_wide > $signed({3'b000, CHAN_MAX})) begin
         tint = CHAN_MAX;
      end else begin
         tint = tint_wide[CHAN_W-1:0];
      end
   end

   assign fore_in = tint * alpha_s1;
   assign back_in = (CHAN_MAX - alpha_s1) * bk_s1_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en_s2) begin
         fore_ff    <= fore_in;
         back_ff    <= back_in;
         tint_s2_ff <= tint;
         bk_s2_ff   <= bk_s1_ff;
      end
   end

   // Stage 3: rounded divide by 255 through the reciprocal form, then select.
   logic [2*CHAN_W:0] blend_sum;
   logic [2*CHAN_W:0] blend_adj;
   logic [CHAN_W:0]   blend_quo;
   logic [CHAN_W-1:0] blend;
   logic [CHAN_W-1:0] chan_in_s3;
   logic [CHAN_W-1:0] chan_out_ff;

   assign blend_sum = {1'b0, fore_ff} + {1'b0, back_ff} + (2*CHAN_W+1)'(ROUND_HALF);
   assign blend_adj = blend_sum + (blend_sum >> CHAN_W) + (2*CHAN_W+1)'(1);
   assign blend_quo = blend_adj[2*CHAN_W:CHAN_W];
   assign blend     = blend_quo[CHAN_W] ? CHAN_MAX : blend_quo[CHAN_W-1:0];

   always_comb begin
      if (!flat_s2 || alpha_s2 == CHAN_MAX) begin
         chan_in_s3 = tint_s2_ff;
      end else if (alpha_s2 == CHAN_ZERO) begin
         chan_in_s3 = bk_s2_ff;
      end else begin
         chan_in_s3 = blend;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en_s3) begin
         chan_out_ff <= chan_in_s3;
      end
   end

   assign chan_out = chan_out_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pixel_tint_alpha_flatten.sv
`default_nettype none

// Duotone tint of one BGR(A) pixel per beat, with optional flattening of the
// alpha onto the background color.
//
// The req_ channel carries one pixel per beat; the rsp_ channel returns one
// pixel per beat, in order. A beat moves when valid is high and stall is low.
// Each color channel runs in its own three-stage lane (multiply, tint and
// blend products, divide by 255 and select), and the top level merges the
// lanes with the alpha path into the result register.
// The accepted pixel passes through the stage 1, 2 and 3 registers, and rsp_valid is
// the stage 3 valid bit. Throughput is one pixel per cycle while rsp_stall is low;
// the rate is set by the three lane stages, each of which holds one pixel.
// When rsp_stall is high the result register holds; the stages behind it keep
// filling, and req_stall rises only once all three stages are occupied.
// Synchronous reset empties the pipeline and restores the color registers:
// foreground white, background black, alpha present, flattening off.
// The csr_ port writes one register per cycle and should only be used while
// the pipeline is empty.
module pixel_tint_alpha_flatten (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [ptaf_pkg::CHAN_W-1:0]      req_blue_in,
   input  wire logic [ptaf_pkg::CHAN_W-1:0]      req_green_in,
   input  wire logic [ptaf_pkg::CHAN_W-1:0]      req_red_in,
   input  wire logic [ptaf_pkg::CHAN_W-1:0]      req_alpha_in,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [ptaf_pkg::CHAN_W-1:0]      rsp_blue_out,
   output logic      [ptaf_pkg::CHAN_W-1:0]      rsp_green_out,
   output logic      [ptaf_pkg::CHAN_W-1:0]      rsp_red_out,
   output logic      [ptaf_pkg::CHAN_W-1:0]      rsp_alpha_out,
   input  wire logic                             csr_write,
   input  wire logic [ptaf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ptaf_pkg::COLOR_W-1:0]     csr_data
);
   import ptaf_pkg::*;

   // Configuration registers.
   logic [COLOR_W-1:0] fg_color_ff;
   logic [COLOR_W-1:0] bk_color_ff;
   logic               has_alpha_ff;
   logic               flatten_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff      <= FG_RESET;
         bk_color_ff      <= BK_RESET;
         has_alpha_ff     <= 1'b1;
         flatten_alpha_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FG_COLOR:      fg_color_ff      <= csr_data;
            CSR_BK_COLOR:      bk_color_ff      <= csr_data;
            CSR_HAS_ALPHA:     has_alpha_ff     <= csr_data[0];
            CSR_FLATTEN_ALPHA: flatten_alpha_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Pipeline control.
   pipe_ctrl_type ctrl;

   ptaf_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // Alpha and flatten decision travel beside the lanes.
   logic [CHAN_W-1:0] alpha_s1_ff, alpha_s2_ff, alpha_out_ff;
   logic              flat_s1_ff, flat_s2_ff, flat_out_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en_s1) begin
         alpha_s1_ff <= req_alpha_in;
         flat_s1_ff  <= has_alpha_ff && flatten_alpha_ff;
      end
      if (ctrl.en_s2) begin
         alpha_s2_ff <= alpha_s1_ff;
         flat_s2_ff  <= flat_s1_ff;
      end
      if (ctrl.en_s3) begin
         alpha_out_ff <= flat_s2_ff ? CHAN_MAX : alpha_s2_ff;
         flat_out_ff  <= flat_s2_ff;
      end
   end

   // One lane for each color channel.
   ptaf_lane u_lane_blue (
      .clock    (clock),
      .ctrl     (ctrl),
      .chan_in  (req_blue_in),
      .fg_chan  (fg_color_ff[BLUE_LSB +: CHAN_W]),
      .bk_chan  (bk_color_ff[BLUE_LSB +: CHAN_W]),
      .alpha_s1 (alpha_s1_ff),
      .alpha_s2 (alpha_s2_ff),
      .flat_s2  (flat_s2_ff),
      .chan_out (rsp_blue_out)
   );

   ptaf_lane u_lane_green (
      .clock    (clock),
      .ctrl     (ctrl),
      .chan_in  (req_green_in),
      .fg_chan  (fg_color_ff[GREEN_LSB +: CHAN_W]),
      .bk_chan  (bk_color_ff[GREEN_LSB +: CHAN_W]),
      .alpha_s1 (alpha_s1_ff),
      .alpha_s2 (alpha_s2_ff),
      .flat_s2  (flat_s2_ff),
      .chan_out (rsp_green_out)
   );

   ptaf_lane u_lane_red (
      .clock    (clock),
      .ctrl     (ctrl),
      .chan_in  (req_red_in),
      .fg_chan  (fg_color_ff[RED_LSB +: CHAN_W]),
      .bk_chan  (bk_color_ff[RED_LSB +: CHAN_W]),
      .alpha_s1 (alpha_s1_ff),
      .alpha_s2 (alpha_s2_ff),
      .flat_s2  (flat_s2_ff),
      .chan_out (rsp_red_out)
   );

   assign rsp_alpha_out = alpha_out_ff;

   // The input is held off only while every stage holds a pixel.
   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (ctrl.vld_s1 && ctrl.vld_s2 && ctrl.vld_s3))
      else $error("req_stall raised with an empty stage");

   // An accepted beat lands in the first stage.
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ctrl.vld_s1)
      else $error("accepted beat lost at stage 1");

   // A flattened result always leaves opaque.
   a_flat_opaque : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && flat_out_ff) |-> (rsp_alpha_out == CHAN_MAX))
      else $error("flattened pixel not opaque");

   // Reset empties the output.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
